// ===== rtl/core/lpm_pkg.sv =====
// Shared types, codes and helpers for the longest prefix match router.
package lpm_pkg;

  localparam int TABLE_DEPTH_DEF = 64;
  localparam int NUM_INTERFACES  = 16;
  localparam int ADDR_W          = 32;
  localparam int LEN_W           = 6;
  localparam int IFC_W           = 4;
  localparam int TTL_W           = 8;
  localparam int STATUS_W        = 3;
  localparam int IFC_CMP_W       = 9;
  localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(ADDR_W);

  typedef enum logic {
    OP_ADD     = 1'b0,
    OP_FORWARD = 1'b1
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    RT_ADDED     = 3'd0,
    RT_DUPLICATE = 3'd1,
    RT_FULL      = 3'd2,
    RT_FORWARDED = 3'd3,
    RT_EXPIRED   = 3'd4,
    RT_NO_ROUTE  = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DONE
  } state_t;

  typedef struct packed {
    op_t               op;
    logic [ADDR_W-1:0] address;
    logic [LEN_W-1:0]  prefix_len;
    logic              has_next_hop;
    logic [ADDR_W-1:0] gateway;
    logic [IFC_W-1:0]  interface_req;
    logic [TTL_W-1:0]  ttl;
  } in_beat_t;

  typedef struct packed {
    status_t           status;
    logic [IFC_W-1:0]  out_interface;
    logic [ADDR_W-1:0] hop_addr;
    logic [TTL_W-1:0]  new_ttl;
  } out_beat_t;

  // One route table entry as held in the RAM.
  typedef struct packed {
    logic [ADDR_W-1:0] prefix;
    logic [LEN_W-1:0]  len;
    logic              has_hop;
    logic [ADDR_W-1:0] hop;
    logic [IFC_W-1:0]  ifc;
  } route_t;

  // Network mask for a prefix length already limited to 0..32.
  function automatic logic [ADDR_W-1:0] len_mask(input logic [LEN_W-1:0] len);
    logic [ADDR_W-1:0] m;
    if (len == '0) begin
      m = '0;
    end else begin
      m = {ADDR_W{1'b1}} << (MAX_LEN - len);
    end
    return m;
  endfunction

endpackage

// ===== rtl/core/lpm_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module lpm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                                   clk,
  input  logic                                   wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                       wr_data,
  input  logic                                   rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                       rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== rtl/core/longest_prefix_match_router.sv =====
// Route table and longest prefix match forwarding lookup, top level.
//
// Usage notes:
//  - Input channel (in_valid/in_ready/in_data): one beat per request. op ADD stores
//    a route (prefix, length, optional next hop, interface); op FORWARD looks up a
//    destination and decrements its TTL.
//  - Result channel (out_valid/out_ready/out_data): exactly one beat per request,
//    in request order, carrying status, interface, next hop and new TTL.
//  - Each request walks the stored routes through one RAM read port, one entry per
//    cycle, into one shared mask/compare unit. A new request is taken only once the
//    sequencer is back in idle after loading the previous result, so lookups do not
//    overlap.
//  - in_ready is high only while the sequencer is idle.
//  - The result sits in an output register. A stalled receiver does not block the
//    next lookup; only the final load waits for the register to free up.
//  - Reset (rst_n low, synchronous) empties the table (route count to zero) and
//    drops any pending result. Table RAM contents are not cleared; only entries
//    below the route count are ever read.
module longest_prefix_match_router #(
  parameter int TABLE_DEPTH = lpm_pkg::TABLE_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  lpm_pkg::in_beat_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output lpm_pkg::out_beat_t out_data
);

  import lpm_pkg::*;

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam logic [CW-1:0] FULL_COUNT = CW'(TABLE_DEPTH);

  // Control state
  state_t         state_r, state_nxt;
  logic [CW-1:0]  count_r, count_nxt;     // stored routes
  logic [CW-1:0]  rd_idx_r, rd_idx_nxt;   // next entry to read
  logic           pend_r, pend_nxt;       // read data valid this cycle
  logic           out_valid_r, out_valid_nxt;

  // Per-request working registers
  in_beat_t       item_r, item_nxt;
  logic           dup_r, dup_nxt;
  logic           found_r, found_nxt;
  route_t         best_r, best_nxt;
  out_beat_t      out_data_r, out_data_nxt;

  // Sequencer outputs
  logic           rd_en;
  logic           load_out;
  logic           wr_en;

  // RAM and compare unit
  route_t            entry;
  route_t            new_route;
  logic [LEN_W-1:0]  cmp_len;
  logic [ADDR_W-1:0] cmp_mask;
  logic              prefix_hit;
  logic              dup_hit;
  logic              better;
  out_beat_t         res;

  lpm_ram #(
    .WIDTH ($bits(route_t)),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (count_r[AW-1:0]),
    .wr_data (new_route),
    .rd_en   (rd_en),
    .rd_addr (rd_idx_r[AW-1:0]),
    .rd_data (entry)
  );

  always_comb begin
    new_route.prefix  = item_r.address;
    new_route.len     = item_r.prefix_len;
    new_route.has_hop = item_r.has_next_hop;
    new_route.hop     = item_r.gateway;
    new_route.ifc     = item_r.interface_req;
  end

  // Shared compare unit: add checks the request's length against each entry,
  // forward applies each entry's own mask to the destination.
  always_comb begin
    cmp_len    = (item_r.op == OP_ADD) ? item_r.prefix_len : entry.len;
    cmp_mask   = len_mask(cmp_len);
    prefix_hit = ((entry.prefix ^ item_r.address) & cmp_mask) == '0;
    dup_hit    = prefix_hit && (entry.len == item_r.prefix_len);
    // strict greater keeps the earliest route on equal lengths
    better     = prefix_hit && (!found_r || (entry.len > best_r.len));
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        if ((rd_idx_r == count_r) && !pend_r) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    in_ready = 1'b0;
    rd_en    = 1'b0;
    load_out = 1'b0;
    unique case (state_r)
      S_IDLE: in_ready = 1'b1;
      S_SCAN: rd_en    = (rd_idx_r != count_r);
      S_DONE: load_out = !out_valid_r || out_ready;
      default: ;
    endcase
    wr_en = load_out && (item_r.op == OP_ADD) && !dup_r && (count_r != FULL_COUNT);
  end

  // Result formation
  always_comb begin
    res = '0;
    if (item_r.op == OP_ADD) begin
      if (dup_r) begin
        res.status = RT_DUPLICATE;
      end else if (count_r == FULL_COUNT) begin
        res.status = RT_FULL;
      end else begin
        res.status = RT_ADDED;
      end
    end else if (item_r.ttl <= TTL_W'(1)) begin
      res.status = RT_EXPIRED;
    end else if (!found_r ||
                 (IFC_CMP_W'(best_r.ifc) >= IFC_CMP_W'(NUM_INTERFACES))) begin
      res.status = RT_NO_ROUTE;
    end else begin
      res.status        = RT_FORWARDED;
      res.out_interface = best_r.ifc;
      res.hop_addr      = best_r.has_hop ? best_r.hop : item_r.address;
      res.new_ttl       = item_r.ttl - TTL_W'(1);
    end
  end

  // Datapath next values
  always_comb begin
    item_nxt      = item_r;
    rd_idx_nxt    = rd_idx_r;
    pend_nxt      = rd_en;
    dup_nxt       = dup_r;
    found_nxt     = found_r;
    best_nxt      = best_r;
    count_nxt     = count_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;

    if (in_valid && in_ready) begin
      item_nxt = in_data;
      if (in_data.prefix_len > MAX_LEN) begin
        item_nxt.prefix_len = MAX_LEN;
      end
      rd_idx_nxt = '0;
      dup_nxt    = 1'b0;
      found_nxt  = 1'b0;
    end

    if (rd_en) begin
      rd_idx_nxt = rd_idx_r + CW'(1);
    end

    if (pend_r) begin
      if (dup_hit) begin
        dup_nxt = 1'b1;
      end
      if (better) begin
        found_nxt = 1'b1;
        best_nxt  = entry;
      end
    end

    if (wr_en) begin
      count_nxt = count_r + CW'(1);
    end

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (load_out) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      rd_idx_r    <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      rd_idx_r    <= rd_idx_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r     <= item_nxt;
    dup_r      <= dup_nxt;
    found_r    <= found_nxt;
    best_r     <= best_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== rtl/core/lpm_checker.sv =====
// Port-level assertions for the router, bound to the top level.
module lpm_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input lpm_pkg::out_beat_t out_data
);

  import lpm_pkg::*;

  logic in_beat;
  assign in_beat = in_valid && in_ready;

  // stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result beat changed while stalled");

  // reset drops any pending result
  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("out_valid set after reset");

  // busy while a lookup runs
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_beat |=> !in_ready)
    else $error("request taken while lookup in progress");

  // no result can appear the cycle after a request is taken
  a_no_instant_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_beat |=> !$rose(out_valid))
    else $error("result appeared too early");

  // unused fields are zero unless forwarded
  a_idle_fields: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) && (out_data.status != RT_FORWARDED) |->
      (out_data.out_interface == '0) && (out_data.hop_addr == '0) &&
      (out_data.new_ttl == '0))
    else $error("nonzero fields on a non-forwarded result");

endmodule

bind longest_prefix_match_router lpm_checker u_lpm_checker (.*);

// ===== dv/tb.sv =====
// Testbench for the longest prefix match router: route adds and forward lookups.
`timescale 1ns / 100ps

module tb;
  import lpm_pkg::*;

  localparam int TABLE_DEPTH  = TABLE_DEPTH_DEF;
  localparam int RANDOM_ITEMS = 400;
  localparam int HOLD_CYCLES  = 400;           // long receiver hold-off
  localparam int TAIL_CYCLES  = TABLE_DEPTH + 16;
  localparam int STALL_LIMIT  = 5000;          // cycles with no beat on either side
  localparam int HOLD_AT      = 120;           // random item that triggers the hold-off
  localparam int DRAIN_AT     = 240;           // random item before which the sender drains

  // One row of the directed stimulus; res only counts when fixed is set.
  typedef struct {
    in_beat_t  req;
    bit        fixed;
    out_beat_t res;
  } plan_row_t;

  logic      clk;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_ready;
  in_beat_t  in_data   = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_beat_t out_data;

  // Shadow copy of the route table, updated as each request beat is accepted.
  logic [ADDR_W-1:0] rt_prefix [TABLE_DEPTH];
  logic [LEN_W-1:0]  rt_len    [TABLE_DEPTH];
  logic              rt_has_hop[TABLE_DEPTH];
  logic [ADDR_W-1:0] rt_hop    [TABLE_DEPTH];
  logic [IFC_W-1:0]  rt_ifc    [TABLE_DEPTH];
  int                rt_count = 0;

  out_beat_t due_results[$];    // results owed by the block, oldest first
  plan_row_t plan[$];
  int        mismatch_cnt = 0;
  int        idle_cycles  = 0;
  int        burst_left   = 0;
  bit        hold_off_req = 1'b0;

  longest_prefix_match_router #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Single reset pulse at the start; never asserted again.
  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
  end

  // Network mask: top len bits set. A shift by the full width clears the
  // vector, so a /32 comes out as all ones and a /0 as zero.
  function automatic logic [ADDR_W-1:0] net_mask(input logic [LEN_W-1:0] len);
    return ~({ADDR_W{1'b1}} >> len);
  endfunction

  // Predicts the result of one request and updates the shadow table.
  function automatic out_beat_t route_lookup(input in_beat_t b);
    out_beat_t         r;
    logic [LEN_W-1:0]  len;
    logic [ADDR_W-1:0] m;
    bit                hit;
    int                best;
    r   = '0;
    hit = 1'b0;
    best = 0;
    if (b.op == OP_ADD) begin
      // lengths above 32 collapse onto a host route
      len = (b.prefix_len > MAX_LEN) ? MAX_LEN : b.prefix_len;
      m   = net_mask(len);
      for (int i = 0; i < rt_count; i++) begin
        if (rt_len[i] == len && ((rt_prefix[i] ^ b.address) & m) == '0) hit = 1'b1;
      end
      // duplicate check wins over the full-table check
      if (hit) begin
        r.status = RT_DUPLICATE;
      end else if (rt_count >= TABLE_DEPTH) begin
        r.status = RT_FULL;
      end else begin
        rt_prefix[rt_count]  = b.address;
        rt_len[rt_count]     = len;
        rt_has_hop[rt_count] = b.has_next_hop;
        rt_hop[rt_count]     = b.gateway;
        rt_ifc[rt_count]     = b.interface_req;
        rt_count++;
        r.status = RT_ADDED;
      end
    end else if (b.ttl <= 1) begin
      r.status = RT_EXPIRED;
    end else begin
      // strictly longer wins, so the earliest of equal lengths is kept
      for (int i = 0; i < rt_count; i++) begin
        if (((rt_prefix[i] ^ b.address) & net_mask(rt_len[i])) == '0 &&
            (!hit || rt_len[i] > rt_len[best])) begin
          hit  = 1'b1;
          best = i;
        end
      end
      if (!hit || int'(rt_ifc[best]) >= NUM_INTERFACES) begin
        r.status = RT_NO_ROUTE;
      end else begin
        r.status        = RT_FORWARDED;
        r.out_interface = rt_ifc[best];
        r.hop_addr      = rt_has_hop[best] ? rt_hop[best] : b.address;
        r.new_ttl       = b.ttl - 1'b1;
      end
    end
    return r;
  endfunction

  function automatic in_beat_t req_add(input logic [ADDR_W-1:0] addr,
                                       input logic [LEN_W-1:0] len, input logic has_hop,
                                       input logic [ADDR_W-1:0] hop,
                                       input logic [IFC_W-1:0] ifc);
    in_beat_t b;
    b               = '0;
    b.op            = OP_ADD;
    b.address       = addr;
    b.prefix_len    = len;
    b.has_next_hop  = has_hop;
    b.gateway       = hop;
    b.interface_req = ifc;
    return b;
  endfunction

  function automatic in_beat_t req_fwd(input logic [ADDR_W-1:0] addr,
                                       input logic [TTL_W-1:0] ttl);
    in_beat_t b;
    b         = '0;
    b.op      = OP_FORWARD;
    b.address = addr;
    b.ttl     = ttl;
    return b;
  endfunction

  function automatic out_beat_t res(input status_t st, input logic [IFC_W-1:0] ifc,
                                    input logic [ADDR_W-1:0] hop,
                                    input logic [TTL_W-1:0] ttl);
    out_beat_t r;
    r.status        = st;
    r.out_interface = ifc;
    r.hop_addr      = hop;
    r.new_ttl       = ttl;
    return r;
  endfunction

  // TTL skewed toward the expiry boundary and the top of the range.
  function automatic logic [TTL_W-1:0] pick_ttl();
    case ($urandom_range(0, 7))
      0: return 8'd0;
      1: return 8'd1;
      2: return 8'd2;
      3: return 8'hFF;
      default: return TTL_W'($urandom);
    endcase
  endfunction

  // Random request. Most are built from routes already in the table so that
  // nested prefixes, duplicates and longest-match choices actually happen;
  // the rest are fresh routes and fully random forwards.
  function automatic in_beat_t random_request();
    in_beat_t          b;
    int                pick;
    int                j;
    logic [LEN_W-1:0]  len;
    logic [ADDR_W-1:0] m;
    b.op            = OP_FORWARD;
    b.address       = $urandom;
    b.prefix_len    = LEN_W'($urandom_range(0, 63));
    b.has_next_hop  = 1'($urandom);
    b.gateway       = $urandom;
    b.interface_req = IFC_W'($urandom);
    b.ttl           = pick_ttl();
    pick = $urandom_range(0, 99);
    j    = (rt_count > 0) ? $urandom_range(0, rt_count - 1) : 0;
    if (rt_count == 0 && pick >= 25 && pick < 85) pick = 0;
    if (pick < 25) begin
      // fresh route; now and then /0 or an over-long length
      b.op = OP_ADD;
      case ($urandom_range(0, 19))
        0:       b.prefix_len = LEN_W'($urandom_range(33, 63));
        1:       b.prefix_len = '0;
        default: b.prefix_len = LEN_W'($urandom_range(1, 32));
      endcase
    end else if (pick < 35) begin
      // more specific route under a stored one
      b.op         = OP_ADD;
      len          = LEN_W'($urandom_range(rt_len[j], 32));
      m            = net_mask(rt_len[j]);
      b.prefix_len = len;
      b.address    = (rt_prefix[j] & m) | (b.address & ~m);
    end else if (pick < 45) begin
      // same prefix and length as a stored route, host bits scrambled
      b.op         = OP_ADD;
      m            = net_mask(rt_len[j]);
      b.prefix_len = rt_len[j];
      b.address    = (rt_prefix[j] & m) | (b.address & ~m);
      if (rt_len[j] == MAX_LEN && $urandom_range(0, 1))
        b.prefix_len = LEN_W'($urandom_range(33, 63));
    end else if (pick < 85) begin
      // destination inside a stored prefix
      m         = net_mask(rt_len[j]);
      b.address = (rt_prefix[j] & m) | (b.address & ~m);
    end
    return b;
  endfunction

  // Offers one beat. Gaps come between bursts, so valid only drops before a
  // new burst and never in the step where the previous beat was taken.
  task automatic offer(input in_beat_t b, input bit fixed, input out_beat_t want);
    out_beat_t pred;
    int        gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 25);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data  <= b;
    do @(posedge clk); while (!in_ready);
    // beat taken at this edge: predictor always runs to keep the table in step
    pred = route_lookup(b);
    due_results.push_back(fixed ? want : pred);
  endtask

  // Sender: directed table, then random requests, then drain and verdict.
  initial begin
    // before any route: lookup misses, expiry beats the table
    plan.push_back('{req_fwd(32'hC0A8_0001, 8'd64), 1'b1,
                     res(RT_NO_ROUTE, '0, '0, '0)});
    plan.push_back('{req_fwd(32'hC0A8_0001, 8'd0), 1'b1, res(RT_EXPIRED, '0, '0, '0)});
    plan.push_back('{req_fwd(32'hC0A8_0001, 8'd1), 1'b1, res(RT_EXPIRED, '0, '0, '0)});
    // all-ones host route, then the same route again and with an over-long length
    plan.push_back('{req_add('1, 6'd32, 1'b1, '1, 4'hF), 1'b1,
                     res(RT_ADDED, '0, '0, '0)});
    plan.push_back('{req_add('1, 6'd32, 1'b0, '0, 4'h1), 1'b1,
                     res(RT_DUPLICATE, '0, '0, '0)});
    plan.push_back('{req_add('1, 6'd63, 1'b0, '0, 4'h2), 1'b1,
                     res(RT_DUPLICATE, '0, '0, '0)});
    // /8 direct route, a duplicate differing only in host bits, a nested /16
    plan.push_back('{req_add(32'h0A00_0000, 6'd8, 1'b0, '0, 4'h0), 1'b1,
                     res(RT_ADDED, '0, '0, '0)});
    plan.push_back('{req_add(32'h0AFF_0000, 6'd8, 1'b1, 32'h1, 4'h5), 1'b1,
                     res(RT_DUPLICATE, '0, '0, '0)});
    plan.push_back('{req_add(32'h0A01_0000, 6'd16, 1'b1, 32'h0A00_00FE, 4'h3), 1'b1,
                     res(RT_ADDED, '0, '0, '0)});
    plan.push_back('{req_fwd(32'h0A01_0203, 8'hFF), 1'b0, '0});
    plan.push_back('{req_fwd(32'h0A02_0304, 8'd2), 1'b0, '0});
    plan.push_back('{req_fwd('1, 8'd128), 1'b0, '0});
    plan.push_back('{req_fwd(32'hFFFF_FFFE, 8'd10), 1'b1,
                     res(RT_NO_ROUTE, '0, '0, '0)});
    // /1 covers the upper half
    plan.push_back('{req_add(32'h8000_0000, 6'd1, 1'b1, 32'h1234_5678, 4'h7), 1'b1,
                     res(RT_ADDED, '0, '0, '0)});
    plan.push_back('{req_fwd(32'hFFFF_FFFE, 8'd10), 1'b0, '0});
    plan.push_back('{req_fwd(32'h7F00_0001, 8'd200), 1'b1,
                     res(RT_NO_ROUTE, '0, '0, '0)});
    // default route: from here on every destination matches something
    plan.push_back('{req_add('0, 6'd0, 1'b0, '0, 4'h9), 1'b1,
                     res(RT_ADDED, '0, '0, '0)});
    plan.push_back('{req_fwd(32'h0102_0304, 8'd3), 1'b0, '0});
    plan.push_back('{req_add(32'h5555_5555, 6'd0, 1'b1, '1, 4'hC), 1'b1,
                     res(RT_DUPLICATE, '0, '0, '0)});
    plan.push_back('{req_add('0, 6'd32, 1'b1, '0, 4'h0), 1'b1,
                     res(RT_ADDED, '0, '0, '0)});
    plan.push_back('{req_fwd('0, 8'hFF), 1'b0, '0});
    plan.push_back('{req_fwd(32'h0A01_0203, 8'd1), 1'b1,
                     res(RT_EXPIRED, '0, '0, '0)});
    plan.push_back('{req_add(32'hAAAA_AAAA, 6'd31, 1'b1, 32'h5555_5555, 4'hA), 1'b1,
                     res(RT_ADDED, '0, '0, '0)});
    plan.push_back('{req_fwd(32'hAAAA_AAAB, 8'd128), 1'b0, '0});

    while (!rst_n) @(posedge clk);

    foreach (plan[k]) offer(plan[k].req, plan[k].fixed, plan[k].res);

    for (int k = 0; k < RANDOM_ITEMS; k++) begin
      // receiver parks for a long stretch while beats keep coming
      if (k == HOLD_AT) hold_off_req = 1'b1;
      // let the pipe run dry once before going on
      if (k == DRAIN_AT) begin
        in_valid <= 1'b0;
        do @(posedge clk); while (due_results.size() != 0);
        burst_left = 0;
      end
      offer(random_request(), 1'b0, '0);
    end

    in_valid <= 1'b0;
    while (due_results.size() != 0) @(posedge clk);
    // any stray beat after the last expected one shows up as unexpected here
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_cnt == 0 && due_results.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Receiver: alternating stretches of always-ready, random stalls and a fixed
  // rotating pattern; one long hold-off when the sender asks for it.
  initial begin
    int         n;
    int         mode;
    bit         held;
    logic [7:0] pat;
    held = 1'b0;
    pat  = 8'b1011_0010;
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_off_req && !held) begin
        held = 1'b1;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      mode = $urandom_range(0, 2);
      n    = $urandom_range(4, 60);
      repeat (n) begin
        case (mode)
          0:       out_ready <= 1'b1;
          1:       out_ready <= ($urandom_range(0, 2) != 0);
          default: begin
            out_ready <= pat[0];
            pat = {pat[0], pat[7:1]};
          end
        endcase
        @(posedge clk);
      end
    end
  end

  // Result checker: every accepted result against the oldest prediction.
  always @(posedge clk) begin : chk_result
    out_beat_t want;
    if (rst_n && out_valid && out_ready) begin
      if (due_results.size() == 0) begin
        $display("%0t: unexpected result status=%0d ifc=%0d hop=%h ttl=%0d", $time,
                 out_data.status, out_data.out_interface, out_data.hop_addr,
                 out_data.new_ttl);
        mismatch_cnt++;
      end else begin
        want = due_results.pop_front();
        if (out_data.status !== want.status) begin
          $display("%0t: status expected %0d actual %0d", $time, want.status,
                   out_data.status);
          mismatch_cnt++;
        end
        if (out_data.out_interface !== want.out_interface) begin
          $display("%0t: out_interface expected %0d actual %0d", $time,
                   want.out_interface, out_data.out_interface);
          mismatch_cnt++;
        end
        if (out_data.hop_addr !== want.hop_addr) begin
          $display("%0t: hop_addr expected %h actual %h", $time,
                   want.hop_addr, out_data.hop_addr);
          mismatch_cnt++;
        end
        if (out_data.new_ttl !== want.new_ttl) begin
          $display("%0t: new_ttl expected %0d actual %0d", $time, want.new_ttl,
                   out_data.new_ttl);
          mismatch_cnt++;
        end
      end
    end
  end

  // Watchdog: ends the run if neither channel moves a beat for too long.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

endmodule
